/* rtl/hs_pkg.sv */
// Package for the heap sorter: sizes, controller commands and datapath status.
package hs_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 16;

  // Commands from the controller to the datapath. At most one is high in a cycle.
  typedef struct packed {
    logic accept;      // An input transfer is taken this cycle.
    logic prep;        // Set up the build and extract indexes from the count.
    logic build_step;  // Start sift-down at the next internal node.
    logic load_rd;     // Read the node that the sift-down begins at.
    logic hold;        // Capture that node's value as the held value.
    logic check;       // Test for children and read both of them.
    logic cmp;         // Compare the larger child against the held value.
    logic swap_rd;     // Read the heap top and the end of the heap.
    logic swap_wr;     // Move the top to the end and hold the old end value.
    logic emit_rd;     // Read the next element in ascending order.
    logic emit_out;    // Present that element as a result.
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic i_zero;      // No internal node is left to heapify.
    logic end_zero;    // The unsorted region has one element left.
    logic child_in;    // The current node has a left child inside the heap.
    logic more;        // The larger child beats the held value.
    logic last_emit;   // The element being emitted is the largest one.
  } sts_t;

endpackage

/* rtl/hs_datapath.sv */
// Datapath of the heap sorter: element memory, indexes, held value and compare.
module hs_datapath import hs_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [DATA_W-1:0] value,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  output logic signed [DATA_W-1:0] sorted_value,
  output logic                     final_result,
  output logic                     overflowed
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic signed [DATA_W-1:0] mem [DEPTH];

  logic [CW-1:0]            count;
  logic                     drop;
  logic [CW-1:0]            i_idx;
  logic [CW-1:0]            end_idx;
  logic [CW-1:0]            size;
  logic [IW-1:0]            node;
  logic [IW-1:0]            k;
  logic signed [DATA_W-1:0] held;
  logic signed [DATA_W-1:0] rd_a;
  logic signed [DATA_W-1:0] rd_b;

  logic [CW-1:0]            child;
  logic [CW-1:0]            child_b;
  logic                     use_b;
  logic signed [DATA_W-1:0] pick_val;
  logic [CW-1:0]            pick_idx;
  logic [CW-1:0]            i_dec;
  logic [IW-1:0]            ra;
  logic [IW-1:0]            rb;
  logic                     we;
  logic [IW-1:0]            wa;
  logic signed [DATA_W-1:0] wd;

  assign child    = {node, 1'b1};
  assign child_b  = child + CW'(1);
  assign use_b    = (child_b < size) && (rd_b > rd_a);
  assign pick_val = use_b ? rd_b : rd_a;
  assign pick_idx = use_b ? child_b : child;
  assign i_dec    = i_idx - CW'(1);

  assign sts.i_zero    = (i_idx == '0);
  assign sts.end_zero  = (end_idx == '0);
  assign sts.child_in  = (child < size);
  assign sts.more      = (pick_val > held);
  assign sts.last_emit = ({1'b0, k} + CW'(1) == count);

  assign sorted_value = rd_a;
  assign final_result = sts.last_emit;
  assign overflowed   = drop;

  always_comb begin
    ra = node;
    rb = child_b[IW-1:0];
    if (cmd.swap_rd) begin
      ra = end_idx[IW-1:0];
      rb = '0;
    end else if (cmd.check) begin
      ra = child[IW-1:0];
    end else if (cmd.emit_rd) begin
      ra = k;
    end
  end

  always_comb begin
    we = 1'b0;
    wa = node;
    wd = held;
    if (cmd.accept && (count < DEPTH_C)) begin
      we = 1'b1;
      wa = count[IW-1:0];
      wd = value;
    end else if (cmd.swap_wr) begin
      we = 1'b1;
      wa = end_idx[IW-1:0];
      wd = rd_b;
    end else if (cmd.check && !sts.child_in) begin
      we = 1'b1;
    end else if (cmd.cmp) begin
      we = 1'b1;
      wd = sts.more ? pick_val : held;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      drop  <= 1'b0;
    end else if (cmd.accept) begin
      if (count < DEPTH_C) begin
        count <= count + CW'(1);
      end else begin
        drop <= 1'b1;
      end
    end else if (cmd.emit_out && sts.last_emit) begin
      count <= '0;
      drop  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      i_idx   <= count >> 1;
      size    <= count;
      end_idx <= count - CW'(1);
      k       <= '0;
    end
    if (cmd.build_step) begin
      node  <= i_dec[IW-1:0];
      i_idx <= i_dec;
    end
    if (cmd.hold) begin
      held <= rd_a;
    end
    if (cmd.swap_wr) begin
      held    <= rd_a;
      node    <= '0;
      size    <= end_idx;
      end_idx <= end_idx - CW'(1);
    end
    if (cmd.cmp && sts.more) begin
      node <= pick_idx[IW-1:0];
    end
    if (cmd.emit_out) begin
      k <= k + IW'(1);
    end
  end

endmodule

/* rtl/hs_ctrl.sv */
// Controller of the heap sorter: load, heap build, extraction and emission sequencing.
module hs_ctrl import hs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic last_item,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic strobe
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_PREP    = 12'b0000_0000_0010,
    S_BUILD   = 12'b0000_0000_0100,
    S_LOAD    = 12'b0000_0000_1000,
    S_HOLD    = 12'b0000_0001_0000,
    S_CHECK   = 12'b0000_0010_0000,
    S_CMP     = 12'b0000_0100_0000,
    S_EXTRACT = 12'b0000_1000_0000,
    S_SWAP_RD = 12'b0001_0000_0000,
    S_SWAP_WR = 12'b0010_0000_0000,
    S_EMIT_RD = 12'b0100_0000_0000,
    S_EMIT    = 12'b1000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   extracting;
  logic   extracting_next;
  state_t sift_ret;

  // When a sift-down ends, go back to the loop that started it.
  assign sift_ret = extracting ? S_EXTRACT : S_BUILD;

  always_comb begin
    state_next      = state;
    extracting_next = extracting;
    case (state)
      S_IDLE: begin
        if (start && last_item) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        extracting_next = 1'b0;
        state_next      = S_BUILD;
      end
      S_BUILD: begin
        if (sts.i_zero) begin
          extracting_next = 1'b1;
          state_next      = S_EXTRACT;
        end else begin
          state_next = S_LOAD;
        end
      end
      S_LOAD:    state_next = S_HOLD;
      S_HOLD:    state_next = S_CHECK;
      S_CHECK:   state_next = sts.child_in ? S_CMP : sift_ret;
      S_CMP:     state_next = sts.more ? S_CHECK : sift_ret;
      S_EXTRACT: state_next = sts.end_zero ? S_EMIT_RD : S_SWAP_RD;
      S_SWAP_RD: state_next = S_SWAP_WR;
      S_SWAP_WR: state_next = S_CHECK;
      S_EMIT_RD: state_next = S_EMIT;
      S_EMIT:    state_next = sts.last_emit ? S_IDLE : S_EMIT_RD;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      extracting <= 1'b0;
    end else begin
      state      <= state_next;
      extracting <= extracting_next;
    end
  end

  assign busy   = (state != S_IDLE);
  assign strobe = (state == S_EMIT);

  always_comb begin
    cmd            = '0;
    cmd.accept     = (state == S_IDLE) && start;
    cmd.prep       = (state == S_PREP);
    cmd.build_step = (state == S_BUILD) && !sts.i_zero;
    cmd.load_rd    = (state == S_LOAD);
    cmd.hold       = (state == S_HOLD);
    cmd.check      = (state == S_CHECK);
    cmd.cmp        = (state == S_CMP);
    cmd.swap_rd    = (state == S_SWAP_RD);
    cmd.swap_wr    = (state == S_SWAP_WR);
    cmd.emit_rd    = (state == S_EMIT_RD);
    cmd.emit_out   = (state == S_EMIT);
  end

endmodule

/* rtl/heap_sorter.sv */
// Top level of the heap sorter: controller and datapath joined by command and status.
// Loading takes in one input transfer per cycle while idle; busy stays low between items of a set.
// After the transfer marked last_item, the heap is built and the elements extracted,
// each build node and each extraction running a sift-down through the heap.
// Results then follow in ascending order, each for one cycle under strobe; no stall.
// Synchronous active-high reset clears the count, the overflow flag and the controller.
module heap_sorter import hs_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     last_item,
  output logic                     strobe,
  output logic signed [DATA_W-1:0] sorted_value,
  output logic                     final_result,
  output logic                     overflowed
);

  cmd_t cmd;
  sts_t sts;

  // The controller walks the sort: it heapifies every internal node from the
  // bottom up, then repeatedly swaps the top into the sorted tail and sifts the
  // new top down, and finally reads the memory out in ascending order.
  hs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_item (last_item),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .strobe    (strobe)
  );

  // The datapath holds the elements in a memory with one write port and two
  // registered read ports, so both children of a node are read in the same cycle.
  // Items that arrive once the memory is full are dropped and flag the set.
  hs_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .value        (value),
    .cmd          (cmd),
    .sts          (sts),
    .sorted_value (sorted_value),
    .final_result (final_result),
    .overflowed   (overflowed)
  );

endmodule
